### rtl/clfb_pkg.sv
`default_nettype none
package clfb_pkg;

    localparam int COLUMNS = 16;
    localparam int ROWS    = 2;
    localparam int DEPTH   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COL_W   = 5;
    localparam int ROW_W   = 1;
    localparam int OP_W    = 3;
    localparam int CHAR_W  = 8;
    localparam int RSEL_W  = 2;
    localparam int CSEL_W  = 5;
    localparam int START_W = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_PUT     = 3'd0;
    localparam logic [OP_W-1:0] OP_LOCATE  = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
    localparam logic [OP_W-1:0] OP_HOME    = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd4;
    localparam logic [OP_W-1:0] OP_REFRESH = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_START = 1'd1;

    localparam logic [START_W-1:0] ROW0_START_RST = 7'd0;
    localparam logic [START_W-1:0] ROW1_START_RST = 7'd64;

    localparam logic [CHAR_W-1:0] SET_ADDR_CMD = 8'h80;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;

    localparam int STEP_W = 2;
    localparam logic [STEP_W-1:0] S_IDLE = 2'd0;
    localparam logic [STEP_W-1:0] S_CMD  = 2'd1;
    localparam logic [STEP_W-1:0] S_DATA = 2'd2;
    localparam logic [STEP_W-1:0] S_NEXT = 2'd3;

    localparam logic [1:0] EMIT_NONE = 2'd0;
    localparam logic [1:0] EMIT_CMD  = 2'd1;
    localparam logic [1:0] EMIT_DATA = 2'd2;

    localparam logic [1:0] COND_ALWAYS   = 2'd0;
    localparam logic [1:0] COND_START    = 2'd1;
    localparam logic [1:0] COND_ROW_END  = 2'd2;
    localparam logic [1:0] COND_LAST_ROW = 2'd3;

    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_ZERO = 2'd1;
    localparam logic [1:0] CNT_COL  = 2'd2;
    localparam logic [1:0] CNT_ROW  = 2'd3;

    typedef struct packed {
        logic              in_rdy;
        logic [1:0]        emit;
        logic [1:0]        cond;
        logic [1:0]        cnt_op;
        logic              clr_pend;
        logic [STEP_W-1:0] jump;
        logic [STEP_W-1:0] seq;
    } t_uword;

    typedef struct packed {
        logic start;
        logic row_end;
        logic last_row;
        logic out_free;
    } t_useq_cond;

    typedef struct packed {
        logic       in_rdy;
        logic [1:0] emit;
        logic [1:0] cnt_op;
        logic       clr_pend;
    } t_useq_ctl;

    function automatic t_uword uprog(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            S_IDLE:  w = '{1'b1, EMIT_NONE, COND_START, CNT_ZERO, 1'b0, S_CMD, S_IDLE};
            S_CMD:   w = '{1'b0, EMIT_CMD, COND_ALWAYS, CNT_HOLD, 1'b0, S_DATA, S_DATA};
            S_DATA:  w = '{1'b0, EMIT_DATA, COND_ROW_END, CNT_COL, 1'b0, S_NEXT, S_DATA};
            S_NEXT:  w = '{1'b0, EMIT_NONE, COND_LAST_ROW, CNT_ROW, 1'b1, S_IDLE, S_CMD};
            default: w = '{1'b1, EMIT_NONE, COND_START, CNT_ZERO, 1'b0, S_CMD, S_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col));
    endfunction

endpackage
`default_nettype wire

### rtl/clfb_in_if.sv
`default_nettype none
interface clfb_in_if;
    logic                          valid;
    logic                          ready;
    logic [clfb_pkg::OP_W-1:0]     operation;
    logic [clfb_pkg::CHAR_W-1:0]   char_code;
    logic [clfb_pkg::RSEL_W-1:0]   row_select;
    logic [clfb_pkg::CSEL_W-1:0]   col_select;

    modport source(output valid, operation, char_code, row_select, col_select, input ready);
    modport sink(input valid, operation, char_code, row_select, col_select, output ready);
endinterface
`default_nettype wire

### rtl/clfb_out_if.sv
`default_nettype none
interface clfb_out_if;
    logic                          valid;
    logic                          ready;
    logic                          register_select;
    logic [clfb_pkg::CHAR_W-1:0]   bus_byte;
    logic                          last;

    modport source(output valid, register_select, bus_byte, last, input ready);
    modport sink(input valid, register_select, bus_byte, last, output ready);
endinterface
`default_nettype wire

### rtl/char_lcd_frame_buffer_refresh.sv
// Character display frame buffer (ROWS x COLUMNS bytes, reset to spaces) with a cursor
// and a refresh sequencer. Put char, locate, clear, home, tick and a refresh with no
// pending flag complete on acceptance; the next beat can be taken in the following cycle.
// A refresh with the pending flag set holds off the input until the sequencer is idle
// again, while it sends ROWS * (COLUMNS + 1) output beats, one per cycle within a row
// while the output is taken; each row costs one set-address step, one step per
// character and one row-advance step of the microcoded sequencer, and the characters
// are read from a store with one write port and one registered read port.
// Clear and reset empty the store at once through per-entry valid bits, so no
// clearing pass runs. Row start addresses must be written by the user through the
// config port only while the block is idle; the block itself does not enforce this.
`default_nettype none
module char_lcd_frame_buffer_refresh (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [clfb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [clfb_pkg::START_W-1:0]     i_cfg_data,
    clfb_in_if.sink                               i_in,
    clfb_out_if.source                            o_out
);
    logic [clfb_pkg::START_W-1:0] r_row0_start;
    logic [clfb_pkg::START_W-1:0] r_row1_start;
    logic [clfb_pkg::COL_W-1:0]   r_ccol;
    logic [clfb_pkg::ROW_W-1:0]   r_crow;
    logic                         r_pend;
    logic [clfb_pkg::DEPTH-1:0]   r_vld;
    logic                         r_rd_vld;
    logic [clfb_pkg::COL_W-1:0]   r_rcol;
    logic [clfb_pkg::ROW_W-1:0]   r_rrow;
    logic [clfb_pkg::COL_W-1:0]   n_rcol;
    logic [clfb_pkg::ROW_W-1:0]   n_rrow;
    logic                         r_out_vld;
    logic                         r_rs;
    logic [clfb_pkg::CHAR_W-1:0]  r_byte;
    logic                         r_last;

    clfb_pkg::t_useq_cond         cond;
    clfb_pkg::t_useq_ctl          ctl;
    logic                         accept;
    logic                         ram_we;
    logic [clfb_pkg::ADDR_W-1:0]  waddr;
    logic [clfb_pkg::ADDR_W-1:0]  raddr;
    logic [clfb_pkg::CHAR_W-1:0]  ram_q;
    logic                         out_free;
    logic                         row_end;
    logic                         last_row;
    logic [clfb_pkg::START_W-1:0] row_start;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;
    assign row_end  = r_rcol == clfb_pkg::COL_W'(clfb_pkg::COLUMNS - 1);
    assign last_row = r_rrow == clfb_pkg::ROW_W'(clfb_pkg::ROWS - 1);

    assign cond.start    = accept && (i_in.operation == clfb_pkg::OP_REFRESH) && r_pend;
    assign cond.row_end  = row_end;
    assign cond.last_row = last_row;
    assign cond.out_free = out_free;

    clfb_useq u_useq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cond (cond),
        .o_ctl  (ctl)
    );

    assign i_in.ready = ctl.in_rdy;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0_start <= clfb_pkg::ROW0_START_RST;
            r_row1_start <= clfb_pkg::ROW1_START_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                clfb_pkg::REG_ROW0_START: r_row0_start <= i_cfg_data;
                clfb_pkg::REG_ROW1_START: r_row1_start <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // cursor, pending flag and store valid bits
    assign ram_we = accept && (i_in.operation == clfb_pkg::OP_PUT);
    assign waddr  = clfb_pkg::cell_addr(r_crow, r_ccol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccol <= '0;
            r_crow <= '0;
            r_pend <= 1'b1;
            r_vld  <= '0;
        end else begin
            if (ctl.clr_pend) begin
                r_pend <= 1'b0;
            end
            if (accept) begin
                unique case (i_in.operation)
                    clfb_pkg::OP_PUT: begin
                        r_vld[waddr] <= 1'b1;
                        if (r_ccol == clfb_pkg::COL_W'(clfb_pkg::COLUMNS - 1)) begin
                            r_ccol <= '0;
                            if (r_crow != clfb_pkg::ROW_W'(clfb_pkg::ROWS - 1)) begin
                                r_crow <= r_crow + 1'b1;
                            end
                        end else begin
                            r_ccol <= r_ccol + 1'b1;
                        end
                    end
                    clfb_pkg::OP_LOCATE: begin
                        if (i_in.row_select >= clfb_pkg::RSEL_W'(clfb_pkg::ROWS - 1)) begin
                            r_crow <= clfb_pkg::ROW_W'(clfb_pkg::ROWS - 1);
                        end else begin
                            r_crow <= clfb_pkg::ROW_W'(i_in.row_select);
                        end
                        if (i_in.col_select >= clfb_pkg::CSEL_W'(clfb_pkg::COLUMNS - 1)) begin
                            r_ccol <= clfb_pkg::COL_W'(clfb_pkg::COLUMNS - 1);
                        end else begin
                            r_ccol <= clfb_pkg::COL_W'(i_in.col_select);
                        end
                    end
                    clfb_pkg::OP_CLEAR: begin
                        r_vld  <= '0;
                        r_ccol <= '0;
                        r_crow <= '0;
                    end
                    clfb_pkg::OP_HOME: begin
                        r_ccol <= '0;
                        r_crow <= '0;
                    end
                    clfb_pkg::OP_TICK: r_pend <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // refresh read counters
    always_comb begin
        unique case (ctl.cnt_op)
            clfb_pkg::CNT_HOLD: begin
                n_rrow = r_rrow;
                n_rcol = r_rcol;
            end
            clfb_pkg::CNT_ZERO: begin
                n_rrow = '0;
                n_rcol = '0;
            end
            clfb_pkg::CNT_COL: begin
                n_rrow = r_rrow;
                n_rcol = row_end ? '0 : r_rcol + 1'b1;
            end
            clfb_pkg::CNT_ROW: begin
                n_rrow = r_rrow + 1'b1;
                n_rcol = '0;
            end
            default: begin
                n_rrow = r_rrow;
                n_rcol = r_rcol;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rrow <= '0;
            r_rcol <= '0;
        end else begin
            r_rrow <= n_rrow;
            r_rcol <= n_rcol;
        end
    end

    // read one cell ahead so the data is ready when the counters get there
    assign raddr = clfb_pkg::cell_addr(n_rrow, n_rcol);

    clfb_ram #(
        .WIDTH(clfb_pkg::CHAR_W),
        .DEPTH(clfb_pkg::DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(waddr),
        .i_wdata(i_in.char_code),
        .i_raddr(raddr),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[raddr];
    end

    // output beat register
    assign row_start = (r_rrow == '0) ? r_row0_start : r_row1_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ctl.emit != clfb_pkg::EMIT_NONE) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit == clfb_pkg::EMIT_CMD) begin
            r_rs   <= 1'b0;
            r_byte <= clfb_pkg::SET_ADDR_CMD + clfb_pkg::CHAR_W'(row_start);
            r_last <= 1'b0;
        end else if (ctl.emit == clfb_pkg::EMIT_DATA) begin
            r_rs   <= 1'b1;
            r_byte <= r_rd_vld ? ram_q : clfb_pkg::SPACE_CHAR;
            r_last <= row_end && last_row;
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.register_select = r_rs;
    assign o_out.bus_byte        = r_byte;
    assign o_out.last            = r_last;

    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_last |-> r_rs)
        else $error("last beat is not a data byte");

    a_no_input_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit != clfb_pkg::EMIT_NONE |-> !i_in.ready)
        else $error("input taken during refresh");

    a_pending_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.clr_pend |=> !r_pend)
        else $error("pending flag not cleared at end of refresh");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ccol < clfb_pkg::COL_W'(clfb_pkg::COLUMNS))
        else $error("cursor column out of range");
endmodule
`default_nettype wire

### rtl/clfb_ram.sv
`default_nettype none
module clfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/clfb_useq.sv
`default_nettype none
module clfb_useq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire clfb_pkg::t_useq_cond i_cond,
    output clfb_pkg::t_useq_ctl       o_ctl
);
    logic [clfb_pkg::STEP_W-1:0] r_step;
    logic [clfb_pkg::STEP_W-1:0] n_step;
    clfb_pkg::t_uword            uw;
    logic                        go;
    logic                        taken;

    assign uw = clfb_pkg::uprog(r_step);
    assign go = (uw.emit == clfb_pkg::EMIT_NONE) || i_cond.out_free;

    always_comb begin
        unique case (uw.cond)
            clfb_pkg::COND_ALWAYS:   taken = 1'b1;
            clfb_pkg::COND_START:    taken = i_cond.start;
            clfb_pkg::COND_ROW_END:  taken = i_cond.row_end;
            clfb_pkg::COND_LAST_ROW: taken = i_cond.last_row;
            default:                 taken = 1'b0;
        endcase
    end

    assign n_step = go ? (taken ? uw.jump : uw.seq) : r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= clfb_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl.in_rdy   = uw.in_rdy;
    assign o_ctl.emit     = go ? uw.emit : clfb_pkg::EMIT_NONE;
    assign o_ctl.cnt_op   = go ? uw.cnt_op : clfb_pkg::CNT_HOLD;
    assign o_ctl.clr_pend = go && taken && uw.clr_pend;
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import clfb_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int SETTLE_CYCLES    = 2 * ROWS * (COLUMNS + 2);
    localparam int RANDOM_PER_PHASE = 106;

    typedef struct packed {
        logic              register_select;
        logic [CHAR_W-1:0] bus_byte;
        logic              last;
    } lcd_beat_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [START_W-1:0]   cfg_data;

    clfb_in_if  in_bus();
    clfb_out_if out_bus();

    char_lcd_frame_buffer_refresh uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    // shadow copy of the display state
    logic [CHAR_W-1:0]  shadow_frame [DEPTH];
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic               refresh_due;
    logic [START_W-1:0] row_start [2];
    lcd_beat_t          display_beats_due [$];

    int errors    = 0;
    int cycles    = 0;
    int idle_pct  = 0;
    int stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic reset_shadow();
        for (int k = 0; k < DEPTH; k++) shadow_frame[k] = SPACE_CHAR;
        cursor_col  = '0;
        cursor_row  = '0;
        refresh_due = 1'b1;
        row_start[REG_ROW0_START] = ROW0_START_RST;
        row_start[REG_ROW1_START] = ROW1_START_RST;
    endtask

    task automatic apply_lcd_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [RSEL_W-1:0] rsel,
                                input logic [CSEL_W-1:0] csel);
        lcd_beat_t b;
        case (op)
            OP_PUT: begin
                shadow_frame[int'(cursor_row) * COLUMNS + int'(cursor_col)] = ch;
                if (cursor_col < COLUMNS - 1) begin
                    cursor_col = cursor_col + 1'b1;
                end else begin
                    cursor_col = '0;
                    if (cursor_row < ROWS - 1) cursor_row = cursor_row + 1'b1;
                end
            end
            OP_LOCATE: begin
                cursor_row = (rsel < ROWS) ? ROW_W'(rsel) : ROW_W'(ROWS - 1);
                cursor_col = (csel < COLUMNS) ? COL_W'(csel) : COL_W'(COLUMNS - 1);
            end
            OP_CLEAR: begin
                for (int k = 0; k < DEPTH; k++) shadow_frame[k] = SPACE_CHAR;
                cursor_col = '0;
                cursor_row = '0;
            end
            OP_HOME: begin
                cursor_col = '0;
                cursor_row = '0;
            end
            OP_TICK: refresh_due = 1'b1;
            OP_REFRESH: begin
                if (refresh_due) begin
                    for (int r = 0; r < ROWS; r++) begin
                        b.register_select = 1'b0;
                        b.bus_byte        = SET_ADDR_CMD + CHAR_W'(row_start[r]);
                        b.last            = 1'b0;
                        display_beats_due.push_back(b);
                        for (int c = 0; c < COLUMNS; c++) begin
                            b.register_select = 1'b1;
                            b.bus_byte        = shadow_frame[r * COLUMNS + c];
                            b.last            = (r == ROWS - 1) && (c == COLUMNS - 1);
                            display_beats_due.push_back(b);
                        end
                    end
                    refresh_due = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_beat();
        lcd_beat_t want;
        if (display_beats_due.size() == 0) begin
            $display("%0t: unexpected beat rs=%0b byte=%02h last=%0b", $time,
                     out_bus.register_select, out_bus.bus_byte, out_bus.last);
            errors++;
        end else begin
            want = display_beats_due.pop_front();
            if (out_bus.register_select !== want.register_select) begin
                $display("%0t: register_select expected %0b actual %0b", $time,
                         want.register_select, out_bus.register_select);
                errors++;
            end
            if (out_bus.bus_byte !== want.bus_byte) begin
                $display("%0t: bus_byte expected %02h actual %02h", $time,
                         want.bus_byte, out_bus.bus_byte);
                errors++;
            end
            if (out_bus.last !== want.last) begin
                $display("%0t: last expected %0b actual %0b", $time,
                         want.last, out_bus.last);
                errors++;
            end
        end
    endtask

    // display side: check each beat, stall at random
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_bus.valid && out_bus.ready) check_beat();
            out_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [RSEL_W-1:0] rsel, input logic [CSEL_W-1:0] csel);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.operation  <= op;
        in_bus.char_code  <= ch;
        in_bus.row_select <= rsel;
        in_bus.col_select <= csel;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        apply_lcd_op(op, ch, rsel, csel);
    endtask

    task automatic drain_block();
        in_bus.valid <= 1'b0;
        while (display_beats_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [START_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        row_start[idx] = data;
        @(posedge i_clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45) return OP_PUT;
        if (roll < 60) return OP_LOCATE;
        if (roll < 63) return OP_CLEAR;
        if (roll < 68) return OP_HOME;
        if (roll < 81) return OP_TICK;
        if (roll < 96) return OP_REFRESH;
        return (roll < 98) ? OP_SPARE6 : OP_SPARE7;
    endfunction

    task automatic test_directed_ops();
        idle_pct  = 0;
        stall_pct = 0;
        send_op(OP_REFRESH, 8'h00, 2'd0, 5'd0);      // pending out of reset
        send_op(OP_REFRESH, 8'hFF, 2'd3, 5'd31);     // nothing pending
        send_op(OP_PUT, 8'h00, 2'd0, 5'd0);
        send_op(OP_PUT, 8'hFF, 2'd3, 5'd31);
        send_op(OP_LOCATE, 8'h00, 2'd3, 5'd31);      // saturates to last cell
        send_op(OP_PUT, 8'hA5, 2'd0, 5'd0);          // wraps within last row
        send_op(OP_PUT, 8'h81, 2'd0, 5'd0);
        send_op(OP_LOCATE, 8'h00, 2'd0, 5'd15);
        send_op(OP_PUT, 8'h5A, 2'd0, 5'd0);          // wraps to next row
        send_op(OP_PUT, 8'h7E, 2'd0, 5'd0);
        send_op(OP_LOCATE, 8'h00, 2'd1, 5'd16);
        send_op(OP_PUT, 8'h33, 2'd0, 5'd0);
        send_op(OP_SPARE6, 8'hFF, 2'd3, 5'd31);
        send_op(OP_SPARE7, 8'h00, 2'd0, 5'd0);
        send_op(OP_TICK, 8'h00, 2'd0, 5'd0);
        send_op(OP_REFRESH, 8'h00, 2'd0, 5'd0);
        send_op(OP_HOME, 8'h00, 2'd2, 5'd20);
        send_op(OP_PUT, 8'h41, 2'd0, 5'd0);
        send_op(OP_TICK, 8'h00, 2'd0, 5'd0);
        send_op(OP_REFRESH, 8'h00, 2'd0, 5'd0);
        send_op(OP_CLEAR, 8'h00, 2'd1, 5'd7);
        send_op(OP_TICK, 8'h00, 2'd0, 5'd0);
        send_op(OP_REFRESH, 8'h00, 2'd0, 5'd0);
        drain_block();
    endtask

    task automatic row_address_case(input logic [START_W-1:0] a0, input logic [START_W-1:0] a1);
        write_reg(REG_ROW0_START, a0);
        write_reg(REG_ROW1_START, a1);
        send_op(OP_LOCATE, 8'h00, 2'd1, 5'd15);
        send_op(OP_PUT, 8'hC3, 2'd0, 5'd0);
        send_op(OP_TICK, 8'h00, 2'd0, 5'd0);
        send_op(OP_REFRESH, 8'h00, 2'd0, 5'd0);
        drain_block();
    endtask

    task automatic test_row_addresses();
        row_address_case(7'd127, 7'd0);
        row_address_case(7'd0, 7'd127);
        row_address_case(START_W'($urandom_range(127)), START_W'($urandom_range(127)));
    endtask

    task automatic test_random_traffic();
        int idle_mix [4];
        int stall_mix [4];
        idle_mix  = '{0, 78, 0, 9};
        stall_mix = '{0, 0, 78, 9};
        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_mix[p];
            stall_pct = stall_mix[p];
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (i == RANDOM_PER_PHASE / 2) drain_block();
                send_op(pick_op(), CHAR_W'($urandom_range(255)),
                        RSEL_W'($urandom_range(3)), CSEL_W'($urandom_range(31)));
            end
            drain_block();
            write_reg(REG_ROW0_START, START_W'($urandom_range(127)));
            write_reg(REG_ROW1_START, START_W'($urandom_range(127)));
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= '0;
        cfg_data          <= '0;
        in_bus.valid      <= 1'b0;
        in_bus.operation  <= OP_PUT;
        in_bus.char_code  <= '0;
        in_bus.row_select <= '0;
        in_bus.col_select <= '0;
        reset_shadow();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_ops();
        test_row_addresses();
        test_random_traffic();
        drain_block();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
